FILE: sv/tpcu_pkg.sv
// ----------------------------------------------------------------------------
// tpcu_pkg
// shared constants, codes and helpers of the tilted prism cell update unit
// ----------------------------------------------------------------------------
package tpcu_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int WORD_WIDTH  = 32;
   localparam int CSR_WIDTH   = 64;
   localparam int CSR_INDEX_WIDTH = 3;

   // divider: quotient bits resolved per pipeline stage
   localparam int QUO_WIDTH  = 32;
   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = QUO_WIDTH / DIV_STEPS;

   // interpolation lanes
   localparam int NUM_LANES = 4;
   localparam int LANE_XLO  = 0;
   localparam int LANE_XHI  = 1;
   localparam int LANE_YLO  = 2;
   localparam int LANE_YHI  = 3;

   // mode three has no meaning: the cell passes unchanged
   typedef enum logic [1:0] {
      MODE_REPLACE = 2'd0,
      MODE_ADD     = 2'd1,
      MODE_ERASE   = 2'd2,
      MODE_NONE    = 2'd3
   } mode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_FACE_ONE_X = 3'd0,
      CSR_FACE_ONE_Y = 3'd1,
      CSR_FACE_TWO_X = 3'd2,
      CSR_FACE_TWO_Y = 3'd3,
      CSR_DEPTH      = 3'd4,
      CSR_MODE       = 3'd5,
      CSR_FILL       = 3'd6
   } csr_index_type;

   // signed value of the low COORD_WIDTH bits of a 32-bit slot
   function automatic logic signed [WORD_WIDTH-1:0] coord(input logic [WORD_WIDTH-1:0] v);
      logic signed [COORD_WIDTH-1:0] c;
      c = signed'(v[COORD_WIDTH-1:0]);
      return WORD_WIDTH'(c);
   endfunction

endpackage

FILE: sv/tpcu_div_pipe.sv
// ----------------------------------------------------------------------------
// tpcu_div_pipe
// pipelined restoring divider, two quotient bits (DIV_STEPS) per stage
// ----------------------------------------------------------------------------
module tpcu_div_pipe (
   input  logic                                  clock,
   input  logic                                  advance,
   input  logic [2*tpcu_pkg::QUO_WIDTH-1:0]      dividend,
   input  logic [tpcu_pkg::QUO_WIDTH-1:0]        divisor,
   output logic [tpcu_pkg::QUO_WIDTH-1:0]        quotient
);

   localparam int QW = tpcu_pkg::QUO_WIDTH;
   localparam int NS = tpcu_pkg::DIV_STAGES;

   logic [QW-1:0] rem_ff [NS];
   logic [QW-1:0] qd_ff  [NS];
   logic [QW-1:0] rem_in [NS];
   logic [QW-1:0] qd_in  [NS];

   for (genvar k = 0; k < NS; k++) begin : g_stage
      logic [QW-1:0] src_rem;
      logic [QW-1:0] src_qd;

      // remainder starts as the upper half, which stays below the divisor
      if (k == 0) begin : g_first
         assign src_rem = dividend[2*QW-1:QW];
         assign src_qd  = dividend[QW-1:0];
      end else begin : g_next
         assign src_rem = rem_ff[k-1];
         assign src_qd  = qd_ff[k-1];
      end

      always_comb begin : p_step
         logic [QW:0]   trial;
         logic [QW-1:0] r;
         logic [QW-1:0] q;
         r = src_rem;
         q = src_qd;
         for (int j = 0; j < tpcu_pkg::DIV_STEPS; j++) begin
            trial = {r, q[QW-1]};
            q = {q[QW-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
               trial = trial - {1'b0, divisor};
               q[0] = 1'b1;
            end
            r = trial[QW-1:0];
         end
         rem_in[k] = r;
         qd_in[k]  = q;
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k] <= rem_in[k];
            qd_ff[k]  <= qd_in[k];
         end
      end
   end

   assign quotient = qd_ff[NS-1];

endmodule

FILE: sv/tilted_prism_cell_update_unit.sv
// ----------------------------------------------------------------------------
// tilted_prism_cell_update_unit
// tests a cell center against a tilted prism and updates the cell
// ----------------------------------------------------------------------------
// usage:
//   - request channel (req_*) carries one model cell per transfer: center
//     x/y/z, current value, empty mark and the final-cell mark
//   - response channel (rsp_*) returns exactly one updated cell per request,
//     in order
//   - csr_* is a plain write port; write the prism faces, depth bounds,
//     mode and fill value only while no cells are in flight
//   - throughput is one cell per cycle while the response is not stalled
//   - the bound interpolation divider resolves two quotient bits per
//     stage for four bounds in parallel
//   - reset clears the csrs and valid bits and empties the pipeline
//   - when the receiver stalls a valid response the whole pipeline freezes
//     and req_stall rises in the same cycle; nothing is dropped or repeated
// ----------------------------------------------------------------------------
module tilted_prism_cell_update_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration
   input  logic                                   csr_write,
   input  logic [tpcu_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [tpcu_pkg::CSR_WIDTH-1:0]         csr_wdata,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [31:0]                     req_cell_x,
   input  logic signed [31:0]                     req_cell_y,
   input  logic signed [31:0]                     req_cell_z,
   input  logic signed [31:0]                     req_cell_value,
   input  logic                                   req_cell_empty,
   input  logic                                   req_final_cell,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [31:0]                     rsp_new_value,
   output logic                                   rsp_new_empty,
   output logic                                   rsp_changed,
   output logic                                   rsp_saturated,
   output logic                                   rsp_final_flag
);

   localparam int W  = tpcu_pkg::WORD_WIDTH;
   localparam int NL = tpcu_pkg::NUM_LANES;
   localparam int NS = tpcu_pkg::DIV_STAGES;

   // ---------------------------------------------------------------- csrs
   logic [63:0] f1x_ff, f1y_ff, f2x_ff, f2y_ff, depth_ff;
   logic [1:0]  mode_ff;
   logic [31:0] fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1x_ff   <= '0;
         f1y_ff   <= '0;
         f2x_ff   <= '0;
         f2y_ff   <= '0;
         depth_ff <= '0;
         mode_ff  <= '0;
         fill_ff  <= '0;
      end else if (csr_write) begin
         unique case (tpcu_pkg::csr_index_type'(csr_index))
            tpcu_pkg::CSR_FACE_ONE_X: f1x_ff   <= csr_wdata;
            tpcu_pkg::CSR_FACE_ONE_Y: f1y_ff   <= csr_wdata;
            tpcu_pkg::CSR_FACE_TWO_X: f2x_ff   <= csr_wdata;
            tpcu_pkg::CSR_FACE_TWO_Y: f2y_ff   <= csr_wdata;
            tpcu_pkg::CSR_DEPTH:      depth_ff <= csr_wdata;
            tpcu_pkg::CSR_MODE:       mode_ff  <= csr_wdata[1:0];
            tpcu_pkg::CSR_FILL:       fill_ff  <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------- derived geometry
   // the depth range test reads the sorted z limits straight from the csr;
   // depth span and per-lane slope magnitude/sign are registered from the
   // csrs, before the first cell after a write reaches them
   logic signed [W-1:0] zlo_in, zhi_in;
   logic [W-1:0]        dz_ff, dz_in;
   logic                dz_zero_ff, dz_zero_in;
   logic signed [W-1:0] b1_ff  [NL];
   logic signed [W-1:0] b1_in  [NL];
   logic [W-1:0]        mag_ff [NL];
   logic [W-1:0]        mag_in [NL];
   logic                neg_ff [NL];
   logic                neg_in [NL];

   always_comb begin : p_geom
      logic signed [W-1:0] a, b;
      logic signed [W-1:0] lo1 [NL];
      logic signed [W-1:0] lo2 [NL];
      logic [63:0]         pk1 [2];
      logic [63:0]         pk2 [2];
      logic signed [W:0]   d;
      pk1[0] = f1x_ff; pk1[1] = f1y_ff;
      pk2[0] = f2x_ff; pk2[1] = f2y_ff;
      for (int p = 0; p < 2; p++) begin
         a = tpcu_pkg::coord(pk1[p][63:32]);
         b = tpcu_pkg::coord(pk1[p][31:0]);
         lo1[2*p]   = (a < b) ? a : b;
         lo1[2*p+1] = (a < b) ? b : a;
         a = tpcu_pkg::coord(pk2[p][63:32]);
         b = tpcu_pkg::coord(pk2[p][31:0]);
         lo2[2*p]   = (a < b) ? a : b;
         lo2[2*p+1] = (a < b) ? b : a;
      end
      for (int i = 0; i < NL; i++) begin
         d = (W+1)'(lo2[i]) - (W+1)'(lo1[i]);
         b1_in[i]  = lo1[i];
         neg_in[i] = d[W];
         mag_in[i] = d[W] ? W'(-d) : d[W-1:0];
      end
      a = tpcu_pkg::coord(depth_ff[63:32]);
      b = tpcu_pkg::coord(depth_ff[31:0]);
      zlo_in = (a < b) ? a : b;
      zhi_in = (a < b) ? b : a;
      d = (W+1)'(zhi_in) - (W+1)'(zlo_in);
      dz_in = d[W-1:0];
      dz_zero_in = (dz_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dz_ff      <= '0;
         dz_zero_ff <= 1'b1;
         for (int i = 0; i < NL; i++) begin
            b1_ff[i]  <= '0;
            mag_ff[i] <= '0;
            neg_ff[i] <= 1'b0;
         end
      end else begin
         dz_ff      <= dz_in;
         dz_zero_ff <= dz_zero_in;
         for (int i = 0; i < NL; i++) begin
            b1_ff[i]  <= b1_in[i];
            mag_ff[i] <= mag_in[i];
            neg_ff[i] <= neg_in[i];
         end
      end
   end

   // ------------------------------------------------------ pipeline control
   // a single enable freezes every stage while a response waits
   logic advance;
   logic rsp_valid_ff;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign advance   = !req_stall;

   // ------------------------------------------- stage 1: depth range test
   logic                s1_valid_ff;
   logic signed [W-1:0] s1_x_ff, s1_y_ff, s1_value_ff;
   logic                s1_empty_ff, s1_final_ff, s1_range_ff;
   logic [W-1:0]        s1_t_ff;
   logic signed [W-1:0] s1_z;
   logic signed [W:0]   s1_tdiff;

   assign s1_z     = tpcu_pkg::coord(req_cell_z);
   assign s1_tdiff = (W+1)'(s1_z) - (W+1)'(zlo_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_x_ff     <= tpcu_pkg::coord(req_cell_x);
         s1_y_ff     <= tpcu_pkg::coord(req_cell_y);
         s1_value_ff <= req_cell_value;
         s1_empty_ff <= req_cell_empty;
         s1_final_ff <= req_final_cell;
         s1_range_ff <= (s1_z >= zlo_in) && (s1_z <= zhi_in);
         s1_t_ff     <= s1_tdiff[W-1:0];
      end
   end

   // ------------------------------------- stage 2: t times slope magnitude
   logic                s2_valid_ff;
   logic signed [W-1:0] s2_x_ff, s2_y_ff, s2_value_ff;
   logic                s2_empty_ff, s2_final_ff, s2_range_ff;
   logic [2*W-1:0]      s2_prod_ff [NL];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_x_ff     <= s1_x_ff;
         s2_y_ff     <= s1_y_ff;
         s2_value_ff <= s1_value_ff;
         s2_empty_ff <= s1_empty_ff;
         s2_final_ff <= s1_final_ff;
         s2_range_ff <= s1_range_ff;
         for (int i = 0; i < NL; i++) begin
            s2_prod_ff[i] <= (2*W)'(s1_t_ff) * (2*W)'(mag_ff[i]);
         end
      end
   end

   // ---------------------------------------------- divider lanes (/ dz)
   logic [W-1:0] quo [NL];

   for (genvar i = 0; i < NL; i++) begin : g_lane
      tpcu_div_pipe u_div (
         .clock    (clock),
         .advance  (advance),
         .dividend (s2_prod_ff[i]),
         .divisor  (dz_ff),
         .quotient (quo[i])
      );
   end

   // sideband riding alongside the divider stages
   logic                dv_valid_ff [NS];
   logic signed [W-1:0] dv_x_ff     [NS];
   logic signed [W-1:0] dv_y_ff     [NS];
   logic signed [W-1:0] dv_value_ff [NS];
   logic                dv_empty_ff [NS];
   logic                dv_final_ff [NS];
   logic                dv_range_ff [NS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) dv_valid_ff[k] <= 1'b0;
      end else if (advance) begin
         dv_valid_ff[0] <= s2_valid_ff;
         for (int k = 1; k < NS; k++) dv_valid_ff[k] <= dv_valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dv_x_ff[0]     <= s2_x_ff;
         dv_y_ff[0]     <= s2_y_ff;
         dv_value_ff[0] <= s2_value_ff;
         dv_empty_ff[0] <= s2_empty_ff;
         dv_final_ff[0] <= s2_final_ff;
         dv_range_ff[0] <= s2_range_ff;
         for (int k = 1; k < NS; k++) begin
            dv_x_ff[k]     <= dv_x_ff[k-1];
            dv_y_ff[k]     <= dv_y_ff[k-1];
            dv_value_ff[k] <= dv_value_ff[k-1];
            dv_empty_ff[k] <= dv_empty_ff[k-1];
            dv_final_ff[k] <= dv_final_ff[k-1];
            dv_range_ff[k] <= dv_range_ff[k-1];
         end
      end
   end

   // ------------------------------------ stage 3: layer bounds and inside
   logic                s3_valid_ff;
   logic signed [W-1:0] s3_value_ff;
   logic                s3_empty_ff, s3_final_ff, s3_inside_ff;
   logic signed [W+1:0] bnd [NL];
   logic                s3_inside_in;

   always_comb begin
      for (int i = 0; i < NL; i++) begin
         // flat prism when the depth span is zero: face one's bounds
         if (dz_zero_ff) begin
            bnd[i] = (W+2)'(b1_ff[i]);
         end else if (neg_ff[i]) begin
            bnd[i] = (W+2)'(b1_ff[i]) - signed'({2'b00, quo[i]});
         end else begin
            bnd[i] = (W+2)'(b1_ff[i]) + signed'({2'b00, quo[i]});
         end
      end
      s3_inside_in = dv_range_ff[NS-1]
         && ((W+2)'(dv_x_ff[NS-1]) >= bnd[tpcu_pkg::LANE_XLO])
         && ((W+2)'(dv_x_ff[NS-1]) <= bnd[tpcu_pkg::LANE_XHI])
         && ((W+2)'(dv_y_ff[NS-1]) >= bnd[tpcu_pkg::LANE_YLO])
         && ((W+2)'(dv_y_ff[NS-1]) <= bnd[tpcu_pkg::LANE_YHI]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= dv_valid_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_value_ff  <= dv_value_ff[NS-1];
         s3_empty_ff  <= dv_empty_ff[NS-1];
         s3_final_ff  <= dv_final_ff[NS-1];
         s3_inside_ff <= s3_inside_in;
      end
   end

   // ------------------------------------------ stage 4: cell update, output
   logic signed [W-1:0] new_value_in, new_value_ff;
   logic                new_empty_in, new_empty_ff;
   logic                changed_in, changed_ff;
   logic                saturated_in, saturated_ff;
   logic                final_ff;
   logic signed [W:0]   sum;

   assign sum = (W+1)'(s3_value_ff) + (W+1)'(signed'(fill_ff));

   always_comb begin
      new_value_in = s3_value_ff;
      new_empty_in = s3_empty_ff;
      changed_in   = 1'b0;
      saturated_in = 1'b0;
      if (s3_inside_ff) begin
         unique case (tpcu_pkg::mode_type'(mode_ff))
            tpcu_pkg::MODE_REPLACE: begin
               changed_in   = 1'b1;
               new_value_in = signed'(fill_ff);
               new_empty_in = 1'b0;
            end
            tpcu_pkg::MODE_ADD: begin
               changed_in   = 1'b1;
               new_empty_in = 1'b0;
               if (s3_empty_ff) begin
                  new_value_in = signed'(fill_ff);
               end else if (sum[W] != sum[W-1]) begin
                  // clamp toward the sign of the true sum
                  saturated_in = 1'b1;
                  new_value_in = sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
               end else begin
                  new_value_in = sum[W-1:0];
               end
            end
            tpcu_pkg::MODE_ERASE: begin
               changed_in   = 1'b1;
               new_value_in = '0;
               new_empty_in = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         new_value_ff <= new_value_in;
         new_empty_ff <= new_empty_in;
         changed_ff   <= changed_in;
         saturated_ff <= saturated_in;
         final_ff     <= s3_final_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_new_value  = new_value_ff;
   assign rsp_new_empty  = new_empty_ff;
   assign rsp_changed    = changed_ff;
   assign rsp_saturated  = saturated_ff;
   assign rsp_final_flag = final_ff;

endmodule

FILE: sv/tpcu_checker.sv
// ----------------------------------------------------------------------------
// tpcu_checker
// port-level checks of the tilted prism cell update unit
// ----------------------------------------------------------------------------
module tpcu_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_new_value,
   input logic               rsp_new_empty,
   input logic               rsp_changed,
   input logic               rsp_saturated
);

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_new_value))
      else $error("stalled response changed");

   // input only backs up behind a stalled response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled response");

   // an erased cell reads zero
   a_erase_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_changed && rsp_new_empty |-> rsp_new_value == 32'sd0)
      else $error("erased cell with nonzero value");

   // clamping only on an update that leaves the cell full
   a_sat_changed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_changed && !rsp_new_empty)
      else $error("saturation without an add update");

endmodule

bind tilted_prism_cell_update_unit tpcu_checker u_tpcu_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_new_value (rsp_new_value),
   .rsp_new_empty (rsp_new_empty),
   .rsp_changed   (rsp_changed),
   .rsp_saturated (rsp_saturated)
);

FILE: tb/tb_tilted_prism_cell_update_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tilted_prism_cell_update_unit
// checks cell updates against a behavioral prism test
// ----------------------------------------------------------------------------
// cells are streamed through the request channel with random gaps and the
// responses are stalled at random. Each accepted cell is predicted in the
// scoreboard and compared, field by field and in order, with the responses.
// Several prism settings are applied between phases: degenerate ones, full
// range extremes, crossing bounds and random ones, in every mode.
// ----------------------------------------------------------------------------
module tb_tilted_prism_cell_update_unit;

   localparam int LATENCY     = 3 + tpcu_pkg::DIV_STAGES;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic signed [31:0] value;
      logic               empty;
      logic               changed;
      logic               saturated;
      logic               final_flag;
   } cell_result_type;

   // ------------------------------------------------------------------------
   // prism predictor and in-order store of predicted cells
   // ------------------------------------------------------------------------
   class prism_scoreboard;
      logic [63:0] face_regs[5];
      logic [1:0]  mode;
      logic signed [31:0] fill;
      cell_result_type predicted_cells[$];
      int mismatches;
      int cells_checked;
      int inside_count;

      function void clear_regs();
         for (int i = 0; i < 5; i++) face_regs[i] = '0;
         mode = tpcu_pkg::MODE_REPLACE;
         fill = '0;
      endfunction

      function void write_reg(tpcu_pkg::csr_index_type idx, logic [63:0] data);
         case (idx)
            tpcu_pkg::CSR_MODE: mode = data[1:0];
            tpcu_pkg::CSR_FILL: fill = data[31:0];
            default:  face_regs[idx] = data;
         endcase
      endfunction

      // low and high limit of a packed pair, sorted
      function void limits(logic [63:0] packed_pair, output longint lo, output longint hi);
         longint a, b;
         a = longint'(tpcu_pkg::coord(packed_pair[63:32]));
         b = longint'(tpcu_pkg::coord(packed_pair[31:0]));
         lo = (a < b) ? a : b;
         hi = (a < b) ? b : a;
      endfunction

      // b1 + trunc(t * (b2 - b1) / dz), product formed exactly
      function longint layer_bound(longint b1, longint b2, longint t, longint dz);
         longint d;
         logic [95:0] q;
         d = b2 - b1;
         q = (96'(t) * 96'((d < 0) ? -d : d)) / 96'(dz);
         return (d < 0) ? b1 - longint'(q) : b1 + longint'(q);
      endfunction

      function void note_cell(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z, logic signed [31:0] val,
                              logic empty, logic fin);
         longint x1lo, x1hi, y1lo, y1hi, x2lo, x2hi, y2lo, y2hi, zlo, zhi;
         longint lxlo, lxhi, lylo, lyhi, cx, cy, cz, total;
         bit hit;
         cell_result_type r;
         limits(face_regs[tpcu_pkg::CSR_FACE_ONE_X], x1lo, x1hi);
         limits(face_regs[tpcu_pkg::CSR_FACE_ONE_Y], y1lo, y1hi);
         limits(face_regs[tpcu_pkg::CSR_FACE_TWO_X], x2lo, x2hi);
         limits(face_regs[tpcu_pkg::CSR_FACE_TWO_Y], y2lo, y2hi);
         limits(face_regs[tpcu_pkg::CSR_DEPTH], zlo, zhi);
         cx = longint'(tpcu_pkg::coord(x));
         cy = longint'(tpcu_pkg::coord(y));
         cz = longint'(tpcu_pkg::coord(z));
         hit = 0;
         if (cz >= zlo && cz <= zhi) begin
            // flat prism: face one bounds only
            if (zhi == zlo) begin
               lxlo = x1lo; lxhi = x1hi; lylo = y1lo; lyhi = y1hi;
            end else begin
               lxlo = layer_bound(x1lo, x2lo, cz - zlo, zhi - zlo);
               lxhi = layer_bound(x1hi, x2hi, cz - zlo, zhi - zlo);
               lylo = layer_bound(y1lo, y2lo, cz - zlo, zhi - zlo);
               lyhi = layer_bound(y1hi, y2hi, cz - zlo, zhi - zlo);
            end
            hit = cx >= lxlo && cx <= lxhi && cy >= lylo && cy <= lyhi;
         end
         r = '{value: val, empty: empty, changed: 0, saturated: 0, final_flag: fin};
         if (hit && mode != tpcu_pkg::MODE_NONE) begin
            inside_count++;
            r.changed = 1;
            case (mode)
               tpcu_pkg::MODE_REPLACE: begin
                  r.value = fill; r.empty = 0;
               end
               tpcu_pkg::MODE_ADD: begin
                  if (empty) r.value = fill;
                  else begin
                     total = longint'(val) + longint'(fill);
                     if (total > 64'sd2147483647) begin
                        total = 64'sd2147483647; r.saturated = 1;
                     end
                     if (total < -64'sd2147483648) begin
                        total = -64'sd2147483648; r.saturated = 1;
                     end
                     r.value = total[31:0];
                  end
                  r.empty = 0;
               end
               default: begin
                  r.value = '0; r.empty = 1;
               end
            endcase
         end
         predicted_cells.push_back(r);
      endfunction

      function void check_cell(cell_result_type got);
         cell_result_type want;
         cells_checked++;
         if (predicted_cells.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response value=%h empty=%b", got.value, got.empty);
            return;
         end
         want = predicted_cells.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("cell %0d: want val=%h e=%b c=%b s=%b f=%b, got val=%h e=%b c=%b s=%b f=%b",
                        cells_checked, want.value, want.empty, want.changed,
                        want.saturated, want.final_flag, got.value, got.empty,
                        got.changed, got.saturated, got.final_flag);
         end
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // block signals
   // ------------------------------------------------------------------------
   logic clock = 0;
   logic reset = 1;
   logic csr_write = 0;
   logic [tpcu_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [tpcu_pkg::CSR_WIDTH-1:0] csr_wdata = '0;
   logic req_valid = 0;
   logic req_stall;
   logic signed [31:0] req_cell_x = '0, req_cell_y = '0, req_cell_z = '0;
   logic signed [31:0] req_cell_value = '0;
   logic req_cell_empty = 0, req_final_cell = 0;
   logic rsp_valid;
   logic rsp_stall = 1;
   logic signed [31:0] rsp_new_value;
   logic rsp_new_empty, rsp_changed, rsp_saturated, rsp_final_flag;

   prism_scoreboard cells = new();
   int cycle_count = 0;
   int phase_count = 0;
   bit rsp_idle_run = 0;

   tilted_prism_cell_update_unit DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // timeout watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tilted_prism_cell_update_unit: mismatch");
         $finish;
      end
   end

   // response side: check on transfer, random stall per response
   int stall_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            cells.check_cell('{rsp_new_value, rsp_new_empty, rsp_changed,
                               rsp_saturated, rsp_final_flag});
         if (rsp_valid && !rsp_stall) begin
            // draw a fresh stall for the next response
            stall_left = rsp_idle_run ? 0 : $urandom_range(0, 13);
            rsp_stall <= (stall_left != 0);
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= (stall_left != 0);
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // driving tasks
   // ------------------------------------------------------------------------
   task automatic write_csr(tpcu_pkg::csr_index_type idx, logic [63:0] data);
      @(posedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      cells.write_reg(idx, data);
      @(posedge clock);
      csr_write <= 0;
   endtask

   // one cell transfer, with a random gap first unless gaps are off
   task automatic send_cell(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [31:0] val, logic empty, logic fin, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_cell_x <= x;
      req_cell_y <= y;
      req_cell_z <= z;
      req_cell_value <= val;
      req_cell_empty <= empty;
      req_final_cell <= fin;
      do @(posedge clock); while (req_stall);
      cells.note_cell(x, y, z, val, empty, fin);
   endtask

   // drop valid right after the last transfer and wait for every cell
   task automatic drain();
      req_valid <= 0;
      while (cells.predicted_cells.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000 + $urandom_range(0, 3);
         1: return 32'h7fff_ffff - $urandom_range(0, 3);
         2: return $urandom;
         default: return 32'(int'($urandom_range(0, 400000)) - 200000);
      endcase
   endfunction

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 3))
         0: return 32'h7fff_0000 + $urandom_range(0, 32'hffff);
         1: return 32'h8000_0000 + $urandom_range(0, 32'hffff);
         default: return $urandom;
      endcase
   endfunction

   // random prism, moderate around the origin or full range when wide, limits in random order
   task automatic set_random_prism(bit wide);
      logic [31:0] a, b;
      for (int i = 0; i < 5; i++) begin
         a = wide ? $urandom : 32'(int'($urandom_range(0, 200000)) - 100000);
         b = wide ? $urandom : 32'(int'($urandom_range(0, 200000)) - 100000);
         write_csr(tpcu_pkg::csr_index_type'(i), {a, b});
      end
      write_csr(tpcu_pkg::CSR_MODE, 64'($urandom_range(0, 3)));
      write_csr(tpcu_pkg::CSR_FILL, 64'(rand_value()));
   endtask

   // a cell, mostly with coordinates in the moderate range around the origin
   task automatic send_random_cell(bit no_gap, bit fin);
      logic [31:0] x, y, z;
      if ($urandom_range(0, 3) != 0) begin
         x = 32'(int'($urandom_range(0, 200000)) - 100000);
         y = 32'(int'($urandom_range(0, 200000)) - 100000);
         z = 32'(int'($urandom_range(0, 200000)) - 100000);
      end else begin
         x = rand_coord(); y = rand_coord(); z = rand_coord();
      end
      send_cell(x, y, z, rand_value(), $urandom_range(0, 1), fin, no_gap);
   endtask

   initial begin
      cells.clear_regs();
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset values: a point prism at the origin, replace with zero
      send_cell(0, 0, 0, 32'h1234_5678, 0, 0, 0);
      send_cell(1, 0, 0, 32'h1234_5678, 1, 0, 0);
      drain();

      // extremes of the full range: whole space, add mode
      write_csr(tpcu_pkg::CSR_FACE_ONE_X, 64'h7fff_ffff_8000_0000);
      write_csr(tpcu_pkg::CSR_FACE_ONE_Y, 64'h8000_0000_7fff_ffff);
      write_csr(tpcu_pkg::CSR_FACE_TWO_X, 64'h8000_0000_7fff_ffff);
      write_csr(tpcu_pkg::CSR_FACE_TWO_Y, 64'h7fff_ffff_8000_0000);
      write_csr(tpcu_pkg::CSR_DEPTH, 64'h8000_0000_7fff_ffff);
      write_csr(tpcu_pkg::CSR_MODE, 64'(tpcu_pkg::MODE_ADD));
      write_csr(tpcu_pkg::CSR_FILL, 64'h7fff_ffff);
      send_cell(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 1);
      send_cell(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 0, 0, 1);
      send_cell(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 0, 0, 0);
      send_cell(0, 0, 0, 32'h8000_0000, 1, 1, 0);
      drain();
      // negative saturation
      write_csr(tpcu_pkg::CSR_FILL, 64'h8000_0000);
      send_cell(5, 5, 5, 32'h8000_0000, 0, 0, 0);
      send_cell(5, 5, 5, 32'hffff_ffff, 0, 0, 0);
      send_cell(5, 5, 5, 32'h7fff_ffff, 0, 1, 0);
      drain();

      // tilted prism, then erase and mode three
      write_csr(tpcu_pkg::CSR_FACE_ONE_X, {32'hffff_0000, 32'h0001_0000});
      write_csr(tpcu_pkg::CSR_FACE_ONE_Y, {32'h0001_0000, 32'hffff_0000});
      write_csr(tpcu_pkg::CSR_FACE_TWO_X, {32'h0003_0000, 32'h0005_0000});
      write_csr(tpcu_pkg::CSR_FACE_TWO_Y, {32'hfffb_0000, 32'hfffd_0000});
      write_csr(tpcu_pkg::CSR_DEPTH, {32'h0000_0000, 32'h0000_0003});
      write_csr(tpcu_pkg::CSR_MODE, 64'(tpcu_pkg::MODE_ERASE));
      send_cell(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0042, 0, 0, 0);
      send_cell(32'h0002_0000, 32'hfffd_0000, 32'h0000_0002, 32'h0000_0042, 0, 0, 0);
      send_cell(32'h0005_0000, 32'hfffb_0000, 32'h0000_0003, 32'h0000_0042, 0, 0, 0);
      send_cell(32'h0005_0000, 32'hfffb_0000, 32'h0000_0004, 32'h0000_0042, 0, 1, 0);
      drain();
      write_csr(tpcu_pkg::CSR_MODE, 64'(tpcu_pkg::MODE_NONE));
      send_cell(0, 0, 0, 32'h0000_0042, 0, 0, 0);
      drain();
      // crossing layers: face two has x min above face one x max, flat depth
      write_csr(tpcu_pkg::CSR_DEPTH, {32'h0000_0007, 32'h0000_0007});
      write_csr(tpcu_pkg::CSR_MODE, 64'(tpcu_pkg::MODE_REPLACE));
      write_csr(tpcu_pkg::CSR_FILL, 64'h0000_abcd);
      send_cell(0, 0, 32'h0000_0007, 32'h1, 1, 0, 0);
      send_cell(0, 0, 32'h0000_0008, 32'h1, 1, 0, 0);
      send_cell(32'h0001_0001, 0, 32'h0000_0007, 32'h1, 1, 1, 0);
      drain();

      // random phases: mostly moderate prisms, a few full-range ones
      for (int p = 0; p < 33; p++) begin
         phase_count++;
         set_random_prism(p % 8 == 7);
         rsp_idle_run = (p % 5 == 2);
         for (int i = 0; i < 50; i++)
            send_random_cell(p % 5 == 2 || p % 7 == 3, i == 49);
         drain();
      end
      rsp_idle_run = 0;

      $display("covered %0d cells, %0d inside the prism, %0d random settings",
               cells.cells_checked, cells.inside_count, phase_count);
      $display("all modes, flat and crossing prisms and add saturation exercised");
      if (cells.mismatches == 0 && cells.predicted_cells.size() == 0)
         $display("tilted_prism_cell_update_unit: match");
      else
         $display("tilted_prism_cell_update_unit: mismatch");
      $finish;
   end
endmodule

FILE: tilted_prism_cell_update_unit.f
sv/tpcu_pkg.sv
sv/tpcu_div_pipe.sv
sv/tilted_prism_cell_update_unit.sv
sv/tpcu_checker.sv
tb/tb_tilted_prism_cell_update_unit.sv
